// ----- src/call_stack_profiler_assert.svh -----
// assertion macros for the profiler rtl
// no dependencies; included by csp_back, the module that carries checks
`ifndef CALL_STACK_PROFILER_ASSERT_SVH
`define CALL_STACK_PROFILER_ASSERT_SVH

// property that holds on every clock edge out of reset
`define CSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CSP_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/csp_pkg.sv -----
// types, codes and defaults for the call stack profiler
// no dependencies; used by csp_front, csp_back and call_stack_profiler
package csp_pkg;

    localparam int STACK_DEPTH_DEF   = 64;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [1:0] REQ_ENTER = 2'd0;
    localparam logic [1:0] REQ_EXIT  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] func_addr;
        logic [63:0] site_addr;
        logic [63:0] timestamp;
        logic        in_interrupt;
        logic [5:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] rec_func;
        logic [63:0] rec_total;
        logic [31:0] rec_calls;
        logic [6:0]  rec_count;
        logic [6:0]  stack_depth;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_ENTER,
        OP_EXIT,
        OP_READ,
        OP_CLEAR,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] func;
        logic [63:0] site;
        logic [63:0] ts;
        logic [5:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic [63:0] func;
        logic [63:0] site;
        logic [63:0] start;
    } t_frame;

    typedef struct packed {
        logic [63:0] func;
        logic [63:0] total;
        logic [31:0] calls;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FRAME,
        S_SCAN,
        S_UPD
    } t_state;

endpackage

// ----- src/csp_front.sv -----
// front end: enable register, event classification and a two-deep command queue
// depends on csp_pkg
module csp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  csp_pkg::t_in_item i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    output logic             o_cmd_valid,
    output csp_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_take
);

    logic          r_enable;
    csp_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;
    csp_pkg::t_cmd cmd_in;
    logic          push_ok, take_ok;

    always_comb begin
        cmd_in.func = i_in.func_addr;
        cmd_in.site = i_in.site_addr;
        cmd_in.ts   = i_in.timestamp;
        cmd_in.idx  = i_in.entry_index;
        case (i_in.req_type)
            csp_pkg::REQ_CLEAR: cmd_in.op = csp_pkg::OP_CLEAR;
            csp_pkg::REQ_READ:  cmd_in.op = csp_pkg::OP_READ;
            csp_pkg::REQ_ENTER: begin
                cmd_in.op = (!r_enable || i_in.in_interrupt) ? csp_pkg::OP_IGNORE
                                                             : csp_pkg::OP_ENTER;
            end
            default: begin
                cmd_in.op = (!r_enable || i_in.in_interrupt) ? csp_pkg::OP_IGNORE
                                                             : csp_pkg::OP_EXIT;
            end
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !take_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (take_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (take_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- src/csp_back.sv -----
// back end: shadow stack, function table with sequential lookup, result register
// depends on csp_pkg and call_stack_profiler_assert.svh
`include "call_stack_profiler_assert.svh"
module csp_back #(
    parameter int STACK_DEPTH   = csp_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = csp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  csp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_out_valid,
    input  logic               i_pop,
    output csp_pkg::t_out_item o_out
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int TAW = $clog2(TABLE_ENTRIES);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);

    csp_pkg::t_state    r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]      r_cnt, n_cnt;
    csp_pkg::t_cmd      r_cmd, n_cmd;
    logic [63:0]        r_elapsed, n_elapsed;
    logic [TAW-1:0]     r_scan, n_scan;
    logic [TAW-1:0]     r_free, n_free;
    logic               r_free_ok, n_free_ok;
    logic [TAW-1:0]     r_slot, n_slot;
    logic               r_out_valid, n_out_valid;
    csp_pkg::t_out_item r_out, n_out;

    csp_pkg::t_frame    r_frames [STACK_DEPTH];
    csp_pkg::t_frame    r_frame_rd;
    csp_pkg::t_entry    r_table [TABLE_ENTRIES];
    csp_pkg::t_entry    r_tab_rd;

    logic               frame_we;
    logic [SAW-1:0]     frame_waddr, frame_raddr;
    csp_pkg::t_frame    frame_wdata;
    logic               tab_we;
    logic [TAW-1:0]     tab_waddr, tab_raddr;
    csp_pkg::t_entry    tab_wdata;
    logic               out_free, hit, fr_ok;
    logic [TAW-1:0]     fr_idx;
    csp_pkg::t_entry    upd;

    function automatic csp_pkg::t_out_item mk_out(input logic [2:0] st,
                                                  input csp_pkg::t_entry e,
                                                  input logic [CW-1:0] cnt,
                                                  input logic [SPW-1:0] sp);
        csp_pkg::t_out_item o;
        o.status      = st;
        o.rec_func    = e.func;
        o.rec_total   = e.total;
        o.rec_calls   = e.calls;
        o.rec_count   = 7'(cnt);
        o.stack_depth = 7'(sp);
        return o;
    endfunction

    assign out_free    = !r_out_valid || i_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_valid     = r_valid;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_elapsed   = r_elapsed;
        n_scan      = r_scan;
        n_free      = r_free;
        n_free_ok   = r_free_ok;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_cmd_take  = 1'b0;
        frame_we    = 1'b0;
        frame_waddr = SAW'(r_sp);
        frame_raddr = SAW'(r_sp - 1'b1);
        frame_wdata = '{func: i_cmd.func, site: i_cmd.site, start: i_cmd.ts};
        tab_we      = 1'b0;
        tab_waddr   = r_slot;
        tab_wdata   = '0;
        tab_raddr   = TAW'(i_cmd.idx);
        hit         = r_valid[r_scan] && (r_tab_rd.func == r_cmd.func);
        fr_ok       = r_free_ok || !r_valid[r_scan];
        fr_idx      = r_free_ok ? r_free : r_scan;
        upd.func    = r_tab_rd.func;
        upd.total   = r_tab_rd.total + r_elapsed;
        upd.calls   = (&r_tab_rd.calls) ? r_tab_rd.calls : r_tab_rd.calls + 32'd1;

        case (r_state)
            csp_pkg::S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    case (i_cmd.op)
                        csp_pkg::OP_CLEAR: begin
                            n_sp        = '0;
                            n_valid     = '0;
                            n_cnt       = '0;
                            n_out_valid = 1'b1;
                            n_out       = mk_out(csp_pkg::ST_OK, '0, '0, '0);
                        end
                        csp_pkg::OP_ENTER: begin
                            n_out_valid = 1'b1;
                            if (r_sp == SPW'(STACK_DEPTH)) begin
                                n_out = mk_out(csp_pkg::ST_OVERFLOW, '0, r_cnt, r_sp);
                            end else begin
                                frame_we = 1'b1;
                                n_sp     = r_sp + 1'b1;
                                n_out    = mk_out(csp_pkg::ST_OK, '0, r_cnt, n_sp);
                            end
                        end
                        csp_pkg::OP_READ: begin
                            if ((32'(i_cmd.idx) < TABLE_ENTRIES) && r_valid[tab_raddr]) begin
                                n_state = csp_pkg::S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out = mk_out(csp_pkg::ST_EMPTY, '0, r_cnt, r_sp);
                            end
                        end
                        csp_pkg::OP_EXIT: begin
                            if (r_sp == '0) begin
                                n_out_valid = 1'b1;
                                n_out = mk_out(csp_pkg::ST_UNDERFLOW, '0, r_cnt, r_sp);
                            end else begin
                                n_sp    = r_sp - 1'b1;
                                n_state = csp_pkg::S_FRAME;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out = mk_out(csp_pkg::ST_IGNORED, '0, r_cnt, r_sp);
                        end
                    endcase
                end
            end
            csp_pkg::S_READ: begin
                n_out_valid = 1'b1;
                n_out       = mk_out(csp_pkg::ST_OK, r_tab_rd, r_cnt, r_sp);
                n_state     = csp_pkg::S_IDLE;
            end
            csp_pkg::S_FRAME: begin
                if ((r_frame_rd.func != r_cmd.func) || (r_frame_rd.site != r_cmd.site)) begin
                    n_out_valid = 1'b1;
                    n_out   = mk_out(csp_pkg::ST_MISMATCH, '0, r_cnt, r_sp);
                    n_state = csp_pkg::S_IDLE;
                end else begin
                    n_elapsed = r_cmd.ts - r_frame_rd.start;
                    n_scan    = '0;
                    n_free_ok = 1'b0;
                    tab_raddr = '0;
                    n_state   = csp_pkg::S_SCAN;
                end
            end
            csp_pkg::S_SCAN: begin
                // table data in r_tab_rd belongs to slot r_scan
                if (hit) begin
                    n_slot    = r_scan;
                    tab_raddr = r_scan;
                    n_state   = csp_pkg::S_UPD;
                end else if (r_scan == TAW'(TABLE_ENTRIES - 1)) begin
                    n_out_valid = 1'b1;
                    n_state     = csp_pkg::S_IDLE;
                    if (fr_ok) begin
                        tab_we          = 1'b1;
                        tab_waddr       = fr_idx;
                        tab_wdata       = '{func: r_cmd.func, total: r_elapsed, calls: 32'd1};
                        n_valid[fr_idx] = 1'b1;
                        n_cnt           = r_cnt + 1'b1;
                        n_out = mk_out(csp_pkg::ST_OK, tab_wdata, n_cnt, r_sp);
                    end else begin
                        n_out = mk_out(csp_pkg::ST_FULL, '0, r_cnt, r_sp);
                    end
                end else begin
                    if (!r_valid[r_scan] && !r_free_ok) begin
                        n_free    = r_scan;
                        n_free_ok = 1'b1;
                    end
                    n_scan    = r_scan + 1'b1;
                    tab_raddr = r_scan + 1'b1;
                end
            end
            csp_pkg::S_UPD: begin
                tab_we      = 1'b1;
                tab_waddr   = r_slot;
                tab_wdata   = upd;
                n_out_valid = 1'b1;
                n_out       = mk_out(csp_pkg::ST_OK, upd, r_cnt, r_sp);
                n_state     = csp_pkg::S_IDLE;
            end
            default: begin
                n_state = csp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csp_pkg::S_IDLE;
            r_sp        <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_free_ok   <= n_free_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_elapsed <= n_elapsed;
        r_scan    <= n_scan;
        r_free    <= n_free;
        r_slot    <= n_slot;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frames[frame_waddr] <= frame_wdata;
        end
        r_frame_rd <= r_frames[frame_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[tab_waddr] <= tab_wdata;
        end
        r_tab_rd <= r_table[tab_raddr];
    end

    `CSP_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH), "stack pointer out of range")
    `CSP_ASSERT(a_cnt_match, i_clk, i_rst_n, 32'(r_cnt) == $countones(r_valid), "entry count drift")
    `CSP_IMPLY(a_clear, i_clk, i_rst_n, o_cmd_take && (i_cmd.op == csp_pkg::OP_CLEAR), (r_valid == '0) && (r_sp == '0), "clear left state")
    `CSP_IMPLY(a_take_idle, i_clk, i_rst_n, r_state != csp_pkg::S_IDLE, !o_cmd_take || (r_state == csp_pkg::S_IDLE), "command taken while busy")

endmodule

// ----- src/call_stack_profiler.sv -----
// top level of the call stack profiler
// depends on csp_pkg, csp_front and csp_back
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------
//  events  | push / full      | i_in  (csp_pkg::t_in_item)
//  results | pop / empty      | o_out (csp_pkg::t_out_item)
//  config  | i_cfg_we         | i_cfg_wdata (enable)
//
// one result per event; enter, clear, ignored, overflow, underflow and empty-slot beats
// are answered from the idle state, a frame mismatch from the frame check and a table read
// from the read state; an exit walks the table one slot per cycle over its single read
// port, and a matched exit then passes through an update state before its result
// the front queue holds two events, so up to two events are still accepted while a result waits
// reset is synchronous and clears stack depth and entry valid bits; no clearing pass
module call_stack_profiler #(
    parameter int STACK_DEPTH   = csp_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = csp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  csp_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output csp_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    logic          cmd_valid, cmd_take, out_valid;
    csp_pkg::t_cmd cmd;

    csp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    csp_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (out_valid),
        .i_pop       (pop),
        .o_out       (o_out)
    );

    assign empty = !out_valid;

endmodule

// ----- tb/tb.sv -----
// testbench for call_stack_profiler: directed and random event streams checked beat by beat
// depends on csp_pkg and the call_stack_profiler rtl; holds its own profiler predictor
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH   = 64;
    localparam int ENTRIES = 64;
    localparam int SETTLE  = ENTRIES + 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    csp_pkg::t_in_item  i_in = '0;
    logic               empty;
    logic               pop = 1'b0;
    csp_pkg::t_out_item o_out;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;

    call_stack_profiler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic        prof_enable;
    logic [63:0] frm_func [DEPTH];
    logic [63:0] frm_site [DEPTH];
    logic [63:0] frm_start[DEPTH];
    int          depth_now;
    logic [63:0] ent_func [ENTRIES];
    logic [63:0] ent_total[ENTRIES];
    logic [31:0] ent_calls[ENTRIES];
    logic        ent_valid[ENTRIES];
    int          ent_count;

    csp_pkg::t_out_item expected_results[$];
    int          errors = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int          pop_stall = 0;
    logic [63:0] func_pool[24];

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %0d at %0t: %s got %h want %h", errors, $realtime, what, got, want);
    endtask

    function automatic void wipe_profile();
        depth_now = 0;
        ent_count = 0;
        for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
    endfunction

    function automatic csp_pkg::t_out_item profile_result(logic [2:0] st, int slot);
        csp_pkg::t_out_item r;
        r = '0;
        r.status = st;
        if (slot >= 0) begin
            r.rec_func  = ent_func[slot];
            r.rec_total = ent_total[slot];
            r.rec_calls = ent_calls[slot];
        end
        r.rec_count   = ent_count[6:0];
        r.stack_depth = depth_now[6:0];
        return r;
    endfunction

    function automatic csp_pkg::t_out_item predict_profile(csp_pkg::t_in_item it);
        int slot;
        int top;
        slot = -1;
        if (it.req_type == csp_pkg::REQ_CLEAR) begin
            wipe_profile();
            return profile_result(csp_pkg::ST_OK, -1);
        end
        if (it.req_type == csp_pkg::REQ_READ) begin
            if (ent_valid[it.entry_index]) return profile_result(csp_pkg::ST_OK, it.entry_index);
            return profile_result(csp_pkg::ST_EMPTY, -1);
        end
        if (!prof_enable || it.in_interrupt) return profile_result(csp_pkg::ST_IGNORED, -1);
        if (it.req_type == csp_pkg::REQ_ENTER) begin
            if (depth_now >= DEPTH) return profile_result(csp_pkg::ST_OVERFLOW, -1);
            frm_func[depth_now]  = it.func_addr;
            frm_site[depth_now]  = it.site_addr;
            frm_start[depth_now] = it.timestamp;
            depth_now++;
            return profile_result(csp_pkg::ST_OK, -1);
        end
        if (depth_now == 0) return profile_result(csp_pkg::ST_UNDERFLOW, -1);
        top = depth_now - 1;
        depth_now--;
        if (frm_func[top] != it.func_addr || frm_site[top] != it.site_addr)
            return profile_result(csp_pkg::ST_MISMATCH, -1);
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && ent_valid[i] && ent_func[i] == it.func_addr) slot = i;
        if (slot < 0) begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !ent_valid[i]) slot = i;
            if (slot < 0) return profile_result(csp_pkg::ST_FULL, -1);
            ent_valid[slot] = 1'b1;
            ent_func[slot]  = it.func_addr;
            ent_total[slot] = '0;
            ent_calls[slot] = '0;
            ent_count++;
        end
        ent_total[slot] += it.timestamp - frm_start[top];
        if (ent_calls[slot] != 32'hFFFF_FFFF) ent_calls[slot]++;
        return profile_result(csp_pkg::ST_OK, slot);
    endfunction

    // one event beat; push stays high across back-to-back beats
    task automatic send_event(csp_pkg::t_in_item it);
        int gap;
        gap = idle_en ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        expected_results.push_back(predict_profile(it));
        @(negedge i_clk);
    endtask

    function automatic csp_pkg::t_in_item make_event(logic [1:0] req, logic [63:0] func,
                                                     logic [63:0] site, logic [63:0] ts);
        csp_pkg::t_in_item it;
        it.req_type     = req;
        it.func_addr    = func;
        it.site_addr    = site;
        it.timestamp    = ts;
        it.in_interrupt = 1'b0;
        it.entry_index  = 6'($urandom);
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_results_drained();
        push <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_enable(logic v);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        prof_enable = v;
    endtask

    // result checker
    always @(posedge i_clk) begin
        csp_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            pop_stall <= idle_en ? $urandom_range(0, 12) : 0;
            if (expected_results.size() == 0) begin
                report("unexpected beat status", o_out.status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.status != want.status) report("status", o_out.status, want.status);
                if (o_out.rec_func != want.rec_func) report("rec_func", o_out.rec_func, want.rec_func);
                if (o_out.rec_total != want.rec_total)
                    report("rec_total", o_out.rec_total, want.rec_total);
                if (o_out.rec_calls != want.rec_calls)
                    report("rec_calls", o_out.rec_calls, want.rec_calls);
                if (o_out.rec_count != want.rec_count)
                    report("rec_count", o_out.rec_count, want.rec_count);
                if (o_out.stack_depth != want.stack_depth)
                    report("stack_depth", o_out.stack_depth, want.stack_depth);
            end
        end
    end

    // receiver: per-beat stalls plus one long hold-off requested by the backpressure test
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic test_directed();
        csp_pkg::t_in_item it;
        logic [63:0] ones;
        ones = '1;
        send_event(make_event(csp_pkg::REQ_ENTER, 64'h10, 64'h20, 64'h30));
        set_enable(1'b1);
        send_event(make_event(csp_pkg::REQ_EXIT, 64'h10, 64'h20, 64'h40));
        it = make_event(csp_pkg::REQ_READ, 0, 0, 0);
        it.entry_index = 6'd0;
        send_event(it);
        it.entry_index = 6'd63;
        send_event(it);
        send_event(make_event(csp_pkg::REQ_ENTER, ones, ones, ones));
        send_event(make_event(csp_pkg::REQ_EXIT, ones, ones, 64'd5));
        it = make_event(csp_pkg::REQ_READ, 0, 0, 0);
        it.entry_index = 6'd0;
        send_event(it);
        send_event(make_event(csp_pkg::REQ_ENTER, ones, ones, 64'd0));
        send_event(make_event(csp_pkg::REQ_EXIT, ones, ones, ones));
        send_event(it);
        send_event(make_event(csp_pkg::REQ_ENTER, 64'h1, 64'h2, 64'h3));
        send_event(make_event(csp_pkg::REQ_EXIT, 64'h9, 64'h2, 64'h4));
        send_event(make_event(csp_pkg::REQ_ENTER, 64'h1, 64'h2, 64'h3));
        send_event(make_event(csp_pkg::REQ_EXIT, 64'h1, 64'h7, 64'h4));
        it = make_event(csp_pkg::REQ_ENTER, 64'h5, 64'h6, 64'h7);
        it.in_interrupt = 1'b1;
        send_event(it);
        it.req_type = csp_pkg::REQ_EXIT;
        send_event(it);
        send_event(make_event(csp_pkg::REQ_CLEAR, ones, ones, ones));
        it = make_event(csp_pkg::REQ_READ, 0, 0, 0);
        it.entry_index = 6'd0;
        send_event(it);
    endtask

    task automatic test_stack_limits();
        for (int i = 0; i <= DEPTH; i++)
            send_event(make_event(csp_pkg::REQ_ENTER, 64'(i), 64'(i + 100), 64'(i * 3)));
        for (int i = DEPTH - 1; i >= -1; i--)
            send_event(make_event(csp_pkg::REQ_EXIT, 64'(i), 64'(i + 100), 64'(i * 7)));
    endtask

    task automatic test_table_full();
        csp_pkg::t_in_item it;
        send_event(make_event(csp_pkg::REQ_CLEAR, 0, 0, 0));
        for (int i = 0; i <= ENTRIES; i++) begin
            send_event(make_event(csp_pkg::REQ_ENTER, rand64(), 64'hAA, 64'(i)));
            send_event(make_event(csp_pkg::REQ_EXIT, frm_func[0], 64'hAA, 64'(i * 9)));
        end
        it = make_event(csp_pkg::REQ_READ, 0, 0, 0);
        it.entry_index = 6'd63;
        send_event(it);
        send_event(make_event(csp_pkg::REQ_CLEAR, 0, 0, 0));
    endtask

    // mostly well-formed call trees over a small function pool, some noise
    task automatic test_random(int n);
        csp_pkg::t_in_item it;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            it = make_event(csp_pkg::REQ_ENTER, func_pool[$urandom_range(0, 23)], rand64(),
                            rand64());
            if (r < 45 && depth_now < DEPTH - 2) begin
                it.site_addr = 64'($urandom_range(0, 7));
            end else if (r < 88 && depth_now > 0) begin
                it.req_type  = csp_pkg::REQ_EXIT;
                it.func_addr = frm_func[depth_now - 1];
                it.site_addr = frm_site[depth_now - 1];
                it.timestamp = ($urandom_range(0, 3) == 0) ? rand64()
                               : frm_start[depth_now - 1] + $urandom_range(0, 5000);
                if ($urandom_range(0, 19) == 0) it.func_addr = rand64();
                if ($urandom_range(0, 19) == 0) it.site_addr = rand64();
            end else begin
                it.req_type     = 2'($urandom);
                it.in_interrupt = 1'($urandom);
                if (it.req_type == csp_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0)
                    it.req_type = csp_pkg::REQ_READ;
            end
            send_event(it);
        end
    endtask

    task automatic test_backpressure();
        // stop offering the last beat while the hold-off starts
        push <= 1'b0;
        hold_req = 1'b1;
        @(negedge i_clk);
        test_random(30);
        wait_results_drained();
        test_random(10);
    endtask

    initial begin
        prof_enable = 1'b0;
        wipe_profile();
        for (int i = 0; i < 24; i++) func_pool[i] = rand64();
        func_pool[0] = '0;
        func_pool[1] = '1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_stack_limits();
        test_table_full();
        test_random(350);
        idle_en = 1'b0;
        test_random(120);
        idle_en = 1'b1;
        test_backpressure();
        set_enable(1'b0);
        test_random(60);
        set_enable(1'b1);
        test_random(380);
        wait_results_drained();
        if (errors == 0)
            $display("PASS call_stack_profiler");
        else
            $display("FAIL call_stack_profiler");
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL call_stack_profiler");
        $finish;
    end

endmodule
